>>> sv/sdhc_pkg.sv
// Shared types and constants for the SD host controller register block.
`timescale 1ns / 1ps

package sdhc_pkg;

  // Register byte offsets of the bus-facing register file.
  localparam logic [7:0] ADDR_BLK      = 8'h04;
  localparam logic [7:0] ADDR_ARG      = 8'h08;
  localparam logic [7:0] ADDR_CMD      = 8'h0C;
  localparam logic [7:0] ADDR_RESP0    = 8'h10;
  localparam logic [7:0] ADDR_RESP1    = 8'h14;
  localparam logic [7:0] ADDR_RESP2    = 8'h18;
  localparam logic [7:0] ADDR_RESP3    = 8'h1C;
  localparam logic [7:0] ADDR_DATA     = 8'h20;
  localparam logic [7:0] ADDR_PRESENT  = 8'h24;
  localparam logic [7:0] ADDR_HOST_CTL = 8'h28;
  localparam logic [7:0] ADDR_CLK_CTL  = 8'h2C;
  localparam logic [7:0] ADDR_IRQ_STAT = 8'h30;
  localparam logic [7:0] ADDR_IRQ_EN   = 8'h34;
  localparam logic [7:0] ADDR_IRQ_SIG  = 8'h38;
  localparam logic [7:0] ADDR_RSVD40   = 8'h40;
  localparam logic [7:0] ADDR_VERSION  = 8'hFC;

  // Access kinds.
  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CSD0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CSD1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CSD2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CSD3 = 2'd3;

  // Card command indexes.
  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_ALL_CID   = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA  = 6'd3;
  localparam logic [5:0] CMD_SELECT    = 6'd7;
  localparam logic [5:0] CMD_IF_COND   = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
  localparam logic [5:0] CMD_STATUS    = 6'd13;
  localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
  localparam logic [5:0] CMD_READ_BLK  = 6'd17;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] ACMD_BUS_WID  = 6'd6;
  localparam logic [5:0] ACMD_OP_COND  = 6'd41;

  // Fixed reply values.
  localparam logic [31:0] PRESENT_STATE = 32'h0003_0800;
  localparam logic [31:0] RCA_REPLY     = 32'h0000_0400;
  localparam logic [31:0] READY_FOR_DAT = 32'h0000_0100;
  localparam logic [31:0] BUS_WID_LOW   = 32'h0000_0120;
  localparam logic [31:0] APP_CMD_REPLY = 32'h0000_0020;
  localparam logic [31:0] OCR_VOLT      = 32'h0030_0000;
  localparam logic [31:0] OCR_CCS       = 32'hC000_0000;
  localparam logic [31:0] OCR_BUSY      = 32'h8000_0000;
  localparam logic [31:0] XFER_STEP     = 32'd4;

  typedef enum logic [3:0] {
    CARD_IDLE = 4'd0,
    CARD_STBY = 4'd3,
    CARD_TRAN = 4'd4
  } card_state_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  addr;
    logic [31:0] wdata;
  } in_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        fetch_valid;
    logic [31:0] fetch_addr;
    logic        error;
  } out_t;

  // Outcome of one command write, from the card reply model.
  typedef struct packed {
    logic              known;
    logic [3:0][31:0]  resp;
    card_state_e       card_state;
    logic              app_pending;
    logic              load_dat_lanes;
    logic [1:0]        dat_lanes;
    logic              load_ptr;
  } card_upd_t;

endpackage

>>> sv/sdhc_card_model.sv
// Card reply model: decodes one command index and gives the card's response.
`timescale 1ns / 1ps

module sdhc_card_model (
  input  logic [5:0]           idx_i,
  input  logic                 app_pending_i,
  input  sdhc_pkg::card_state_e card_state_i,
  input  logic [31:0]          arg_i,
  input  logic [3:0][31:0]     csd_i,
  output sdhc_pkg::card_upd_t  upd_o
);

  logic [31:0] status_cur;
  logic [31:0] ocr;

  assign status_cur = {19'd0, card_state_i, 9'd0} | sdhc_pkg::READY_FOR_DAT;

  always_comb begin
    ocr = sdhc_pkg::OCR_VOLT | sdhc_pkg::OCR_BUSY;
    if ((arg_i & sdhc_pkg::OCR_VOLT) != 32'd0) begin
      ocr = ocr | sdhc_pkg::OCR_CCS;
    end
  end

  always_comb begin
    upd_o                = '0;
    upd_o.card_state     = card_state_i;
    upd_o.app_pending    = 1'b0;
    upd_o.known          = 1'b1;
    if (app_pending_i) begin
      case (idx_i)
        sdhc_pkg::ACMD_BUS_WID: begin
          upd_o.load_dat_lanes = 1'b1;
          upd_o.dat_lanes      = arg_i[1:0];
          upd_o.resp[0]        = {19'd0, card_state_i, 9'd0} | sdhc_pkg::BUS_WID_LOW;
        end
        sdhc_pkg::ACMD_OP_COND: begin
          upd_o.resp[0] = ocr;
        end
        default: begin
          upd_o.known = 1'b0;
        end
      endcase
    end else begin
      case (idx_i)
        sdhc_pkg::CMD_GO_IDLE: begin
          upd_o.card_state = sdhc_pkg::CARD_IDLE;
        end
        sdhc_pkg::CMD_ALL_CID: begin
        end
        sdhc_pkg::CMD_SEND_RCA: begin
          upd_o.resp[0] = sdhc_pkg::RCA_REPLY;
        end
        sdhc_pkg::CMD_SELECT: begin
          upd_o.card_state = sdhc_pkg::CARD_STBY;
          upd_o.resp[0]    = {19'd0, sdhc_pkg::CARD_STBY, 9'd0} | sdhc_pkg::READY_FOR_DAT;
        end
        sdhc_pkg::CMD_IF_COND: begin
          upd_o.resp[0] = {20'd0, arg_i[11:0]};
        end
        sdhc_pkg::CMD_SEND_CSD: begin
          // The CSD words are stored shifted by one byte, without the CRC.
          upd_o.resp[3] = {csd_i[3][7:0], csd_i[0][31:8]};
          upd_o.resp[2] = {csd_i[0][7:0], csd_i[1][31:8]};
          upd_o.resp[1] = {csd_i[1][7:0], csd_i[2][31:8]};
          upd_o.resp[0] = {csd_i[2][7:0], csd_i[3][31:8]};
        end
        sdhc_pkg::CMD_STATUS: begin
          upd_o.card_state = sdhc_pkg::CARD_TRAN;
          upd_o.resp[0]    = {19'd0, sdhc_pkg::CARD_TRAN, 9'd0} | sdhc_pkg::READY_FOR_DAT;
        end
        sdhc_pkg::CMD_BLOCKLEN: begin
          upd_o.resp[0] = status_cur;
        end
        sdhc_pkg::CMD_READ_BLK: begin
          upd_o.load_ptr = 1'b1;
        end
        sdhc_pkg::CMD_APP: begin
          upd_o.app_pending = 1'b1;
          upd_o.resp[0]     = sdhc_pkg::APP_CMD_REPLY;
        end
        default: begin
          upd_o.known = 1'b0;
        end
      endcase
    end
  end

endmodule

>>> sv/sd_host_controller_registers.sv
// Top level of the SD host controller register file with card reply model.
//
//   Channel   Direction  Handshake                  Payload
//   in        in         in_valid_i / in_ready_o    in_i  (cmd, addr, wdata)
//   out       out        out_valid_o / out_ready_i  out_o (rdata, fetch_valid,
//                                                          fetch_addr, error)
//   cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_wdata_i
//
// Every bus access is decoded and the register file is updated at the edge
// where its transfer completes, and its result is written into a two-entry
// output buffer at that same edge, visible on out_o in the following cycle
// unless the head entry is stalled. One access per cycle is sustained as
// long as the output side takes results; the second buffer entry absorbs
// one stall; in_ready_o drops only when both entries hold results. Reset is
// asynchronous and active low, clears the whole register file and the CSD
// words, and empties the output buffer. Configuration writes are always taken.
`timescale 1ns / 1ps

module sd_host_controller_registers (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sdhc_pkg::in_t                      in_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sdhc_pkg::out_t                     out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sdhc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [31:0]                        cfg_wdata_i
);

  // Card-specific data words, written through the configuration port.
  logic [3:0][31:0] csd_q;

  // Register file state.
  logic [11:0]           blk_size_q, blk_size_d;
  logic [15:0]           blk_count_q, blk_count_d;
  logic [31:0]           cmd_arg_q, cmd_arg_d;
  logic [15:0]           xfer_mode_q, xfer_mode_d;
  logic [15:0]           cmd_word_q, cmd_word_d;
  logic [3:0][31:0]      resp_q, resp_d;
  logic [31:0]           host_ctl_q, host_ctl_d;
  logic [15:0]           clock_ctl_q, clock_ctl_d;
  logic [7:0]            timeout_ctl_q, timeout_ctl_d;
  logic [31:0]           irq_stat_q, irq_stat_d;
  logic [31:0]           irq_en_q, irq_en_d;
  logic [31:0]           irq_sig_q, irq_sig_d;
  sdhc_pkg::card_state_e card_state_q, card_state_d;
  logic                  app_pending_q, app_pending_d;
  logic [1:0]            dat_lanes_q, dat_lanes_d;
  logic [31:0]           xfer_ptr_q, xfer_ptr_d;

  // Output buffer: head entry drives the port, the skid entry holds one more.
  sdhc_pkg::out_t out_q, skid_q, res;
  logic           out_valid_q, skid_valid_q;

  logic                in_fire, out_fire;
  logic [31:0]         cmd_wr_word;
  sdhc_pkg::card_upd_t card_upd;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_o       = out_q;
  assign cfg_ready_o = 1'b1;

  // The card model only matters on a command register write; its index comes
  // straight from bits 29:24 of the written word.
  assign cmd_wr_word = in_i.wdata;

  sdhc_card_model u_card (
    .idx_i         (cmd_wr_word[29:24]),
    .app_pending_i (app_pending_q),
    .card_state_i  (card_state_q),
    .arg_i         (cmd_arg_q),
    .csd_i         (csd_q),
    .upd_o         (card_upd)
  );

  // Decode of one access: the next register file state and the result item.
  always_comb begin
    blk_size_d    = blk_size_q;
    blk_count_d   = blk_count_q;
    cmd_arg_d     = cmd_arg_q;
    xfer_mode_d   = xfer_mode_q;
    cmd_word_d    = cmd_word_q;
    resp_d        = resp_q;
    host_ctl_d    = host_ctl_q;
    clock_ctl_d   = clock_ctl_q;
    timeout_ctl_d = timeout_ctl_q;
    irq_stat_d    = irq_stat_q;
    irq_en_d      = irq_en_q;
    irq_sig_d     = irq_sig_q;
    card_state_d  = card_state_q;
    app_pending_d = app_pending_q;
    dat_lanes_d   = dat_lanes_q;
    xfer_ptr_d    = xfer_ptr_q;
    res           = '0;

    if (in_i.cmd == sdhc_pkg::ACC_READ) begin
      case (in_i.addr)
        sdhc_pkg::ADDR_BLK:      res.rdata = {blk_count_q, 4'd0, blk_size_q};
        sdhc_pkg::ADDR_RESP0:    res.rdata = resp_q[0];
        sdhc_pkg::ADDR_RESP1:    res.rdata = resp_q[1];
        sdhc_pkg::ADDR_RESP2:    res.rdata = resp_q[2];
        sdhc_pkg::ADDR_RESP3:    res.rdata = resp_q[3];
        sdhc_pkg::ADDR_DATA: begin
          // The data port hands out the card image offset and steps past it.
          res.fetch_valid = 1'b1;
          res.fetch_addr  = xfer_ptr_q;
          xfer_ptr_d      = xfer_ptr_q + sdhc_pkg::XFER_STEP;
        end
        sdhc_pkg::ADDR_PRESENT:  res.rdata = sdhc_pkg::PRESENT_STATE;
        sdhc_pkg::ADDR_HOST_CTL: res.rdata = host_ctl_q;
        sdhc_pkg::ADDR_CLK_CTL:  res.rdata = {8'd0, timeout_ctl_q, clock_ctl_q};
        sdhc_pkg::ADDR_IRQ_STAT: res.rdata = irq_stat_q;
        default: begin
          // Enable, signal, the reserved word and the version word read as zero.
          if (!(in_i.addr inside {sdhc_pkg::ADDR_IRQ_EN, sdhc_pkg::ADDR_IRQ_SIG,
                                  sdhc_pkg::ADDR_RSVD40, sdhc_pkg::ADDR_VERSION})) begin
            res.error = 1'b1;
          end
        end
      endcase
    end else begin
      case (in_i.addr)
        sdhc_pkg::ADDR_BLK: begin
          blk_size_d  = in_i.wdata[11:0];
          blk_count_d = in_i.wdata[31:16];
        end
        sdhc_pkg::ADDR_ARG:      cmd_arg_d = in_i.wdata;
        sdhc_pkg::ADDR_CMD: begin
          // Every command write latches mode and command and replaces the
          // responses with the card model's reply; the app flag is consumed by whatever follows it.
          xfer_mode_d   = in_i.wdata[15:0];
          cmd_word_d    = in_i.wdata[31:16];
          resp_d        = card_upd.resp;
          card_state_d  = card_upd.card_state;
          app_pending_d = card_upd.app_pending;
          if (card_upd.load_dat_lanes) begin
            dat_lanes_d = card_upd.dat_lanes;
          end
          if (card_upd.load_ptr) begin
            xfer_ptr_d = cmd_arg_q;
          end
          if (card_upd.known) begin
            irq_stat_d = irq_stat_q | 32'd3;
          end else begin
            res.error = 1'b1;
          end
        end
        sdhc_pkg::ADDR_HOST_CTL: host_ctl_d = in_i.wdata;
        sdhc_pkg::ADDR_CLK_CTL: begin
          // Clock enable reports clock stable at once.
          clock_ctl_d   = in_i.wdata[15:0] | {14'd0, in_i.wdata[0], 1'b0};
          timeout_ctl_d = in_i.wdata[23:16];
          if (in_i.wdata[24]) begin
            // Controller reset keeps block size, block count and the pointer.
            cmd_arg_d     = '0;
            xfer_mode_d   = '0;
            cmd_word_d    = '0;
            resp_d        = '0;
            host_ctl_d    = '0;
            clock_ctl_d   = '0;
            timeout_ctl_d = '0;
            irq_stat_d    = '0;
            irq_en_d      = '0;
            irq_sig_d     = '0;
            card_state_d  = sdhc_pkg::CARD_IDLE;
            app_pending_d = 1'b0;
            dat_lanes_d   = '0;
          end
        end
        sdhc_pkg::ADDR_IRQ_STAT: irq_stat_d = irq_stat_q & ~in_i.wdata;
        sdhc_pkg::ADDR_IRQ_EN:   irq_en_d   = in_i.wdata;
        sdhc_pkg::ADDR_IRQ_SIG:  irq_sig_d  = in_i.wdata;
        default:                 res.error  = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_size_q    <= '0;
      blk_count_q   <= '0;
      cmd_arg_q     <= '0;
      xfer_mode_q   <= '0;
      cmd_word_q    <= '0;
      resp_q        <= '0;
      host_ctl_q    <= '0;
      clock_ctl_q   <= '0;
      timeout_ctl_q <= '0;
      irq_stat_q    <= '0;
      irq_en_q      <= '0;
      irq_sig_q     <= '0;
      card_state_q  <= sdhc_pkg::CARD_IDLE;
      app_pending_q <= 1'b0;
      dat_lanes_q   <= '0;
      xfer_ptr_q    <= '0;
    end else if (in_fire) begin
      blk_size_q    <= blk_size_d;
      blk_count_q   <= blk_count_d;
      cmd_arg_q     <= cmd_arg_d;
      xfer_mode_q   <= xfer_mode_d;
      cmd_word_q    <= cmd_word_d;
      resp_q        <= resp_d;
      host_ctl_q    <= host_ctl_d;
      clock_ctl_q   <= clock_ctl_d;
      timeout_ctl_q <= timeout_ctl_d;
      irq_stat_q    <= irq_stat_d;
      irq_en_q      <= irq_en_d;
      irq_sig_q     <= irq_sig_d;
      card_state_q  <= card_state_d;
      app_pending_q <= app_pending_d;
      dat_lanes_q   <= dat_lanes_d;
      xfer_ptr_q    <= xfer_ptr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csd_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sdhc_pkg::CFG_CSD0: csd_q[0] <= cfg_wdata_i;
        sdhc_pkg::CFG_CSD1: csd_q[1] <= cfg_wdata_i;
        sdhc_pkg::CFG_CSD2: csd_q[2] <= cfg_wdata_i;
        sdhc_pkg::CFG_CSD3: csd_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Output buffer control. The skid entry is only ever filled while the head
  // entry is stalled, so it is empty whenever the head is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= in_fire;
      end else begin
        out_valid_q  <= in_fire;
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (in_fire) begin
          skid_q <= res;
        end
      end else if (in_fire) begin
        out_q <= res;
      end
    end else if (in_fire) begin
      skid_q <= res;
    end
  end

  // A held skid entry always sits behind a valid head entry.
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid while head entry empty");

  // A data-port read steps the fetch pointer by one word.
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.cmd == sdhc_pkg::ACC_READ && in_i.addr == sdhc_pkg::ADDR_DATA)
    |=> xfer_ptr_q == $past(xfer_ptr_q) + sdhc_pkg::XFER_STEP)
    else $error("data port pointer did not advance by one word");

  // A controller reset write returns the card to idle and drops the app flag.
  a_ctrl_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.cmd == sdhc_pkg::ACC_WRITE && in_i.addr == sdhc_pkg::ADDR_CLK_CTL
     && in_i.wdata[24])
    |=> (card_state_q == sdhc_pkg::CARD_IDLE && !app_pending_q && irq_stat_q == 32'd0))
    else $error("controller reset left card or interrupt state behind");

  // An accepted access always leaves a valid head entry in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted access produced no result");

endmodule
